FILE: rtl/core/pdms_pkg.sv
// Shared types and constants for the PID drive controller with minimum speed.
// Used by every module under rtl/core; depends on nothing else.
package pdms_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DerivW = 18;
  localparam int unsigned IntegW = 32;
  localparam int unsigned MinW   = 15;
  localparam int unsigned PProdW = ErrW + DataW;
  localparam int unsigned IProdW = IntegW + DataW;
  localparam int unsigned DProdW = DerivW + DataW;
  localparam int unsigned SumW   = IProdW + 1;
  localparam int unsigned QuotW  = SumW - 8;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INT_WINDOW = 3'd4;

  localparam logic [DataW-1:0] WindowReset = 16'd40;

  typedef struct packed {
    logic [DataW-1:0] gain_p;
    logic [DataW-1:0] gain_i;
    logic [DataW-1:0] gain_d;
    logic [MinW-1:0]  min_speed;
    logic [DataW-1:0] int_window;
  } cfg_t;

endpackage

FILE: rtl/core/pdms_front.sv
// Error, windowed saturating integral and derivative stage; holds the loop state.
// Depends on pdms_pkg.
module pdms_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic signed [pdms_pkg::DataW-1:0] target_i,
  input  logic signed [pdms_pkg::DataW-1:0] measured_i,
  input  logic [pdms_pkg::DataW-1:0]        window_i,
  output logic signed [pdms_pkg::ErrW-1:0]   err_o,
  output logic signed [pdms_pkg::IntegW-1:0] integ_o,
  output logic signed [pdms_pkg::DerivW-1:0] deriv_o
);

  logic signed [pdms_pkg::ErrW-1:0]   err_d, err_q;
  logic signed [pdms_pkg::IntegW-1:0] integ_d, integ_q;
  logic signed [pdms_pkg::DerivW-1:0] deriv_d, deriv_q;
  logic signed [pdms_pkg::IntegW:0]   integ_sum;
  logic [pdms_pkg::ErrW-1:0]          err_mag;
  logic                               clear;

  assign err_d   = pdms_pkg::ErrW'(target_i) - pdms_pkg::ErrW'(measured_i);
  assign err_mag = err_d[pdms_pkg::ErrW-1] ? -err_d : err_d;
  assign clear   = (err_d == '0) || (err_mag > pdms_pkg::ErrW'(window_i));

  // err_q still holds the previous request's error, which is the derivative base.
  assign deriv_d   = pdms_pkg::DerivW'(err_d) - pdms_pkg::DerivW'(err_q);
  assign integ_sum = (pdms_pkg::IntegW+1)'(integ_q) + (pdms_pkg::IntegW+1)'(err_d);

  always_comb begin
    if (clear) begin
      integ_d = '0;
    end else if (integ_sum[pdms_pkg::IntegW] != integ_sum[pdms_pkg::IntegW-1]) begin
      integ_d = integ_sum[pdms_pkg::IntegW] ? {1'b1, {(pdms_pkg::IntegW-1){1'b0}}}
                                            : {1'b0, {(pdms_pkg::IntegW-1){1'b1}}};
    end else begin
      integ_d = integ_sum[pdms_pkg::IntegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= '0;
      integ_q <= '0;
    end else if (load_i) begin
      err_q   <= err_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      deriv_q <= deriv_d;
    end
  end

  assign err_o   = err_q;
  assign integ_o = integ_q;
  assign deriv_o = deriv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && (err_d == '0) |=> integ_q == '0)
    else $error("integral not cleared on zero error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && (err_mag > pdms_pkg::ErrW'(window_i)) |=> integ_q == '0)
    else $error("integral not cleared outside window");

endmodule

FILE: rtl/core/pdms_mult.sv
// Gain multiply stage: one registered product per term.
// Depends on pdms_pkg.
module pdms_mult (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic signed [pdms_pkg::ErrW-1:0]   err_i,
  input  logic signed [pdms_pkg::IntegW-1:0] integ_i,
  input  logic signed [pdms_pkg::DerivW-1:0] deriv_i,
  input  pdms_pkg::cfg_t                     cfg_i,
  output logic signed [pdms_pkg::PProdW-1:0] p_prod_o,
  output logic signed [pdms_pkg::IProdW-1:0] i_prod_o,
  output logic signed [pdms_pkg::DProdW-1:0] d_prod_o,
  output logic signed [pdms_pkg::ErrW-1:0]   err_o
);

  logic signed [pdms_pkg::PProdW-1:0] p_prod_d, p_prod_q;
  logic signed [pdms_pkg::IProdW-1:0] i_prod_d, i_prod_q;
  logic signed [pdms_pkg::DProdW-1:0] d_prod_d, d_prod_q;
  logic signed [pdms_pkg::ErrW-1:0]   err_q;

  assign p_prod_d = pdms_pkg::PProdW'(err_i) *
                    pdms_pkg::PProdW'($signed(cfg_i.gain_p));
  assign i_prod_d = pdms_pkg::IProdW'(integ_i) *
                    pdms_pkg::IProdW'($signed(cfg_i.gain_i));
  assign d_prod_d = pdms_pkg::DProdW'(deriv_i) *
                    pdms_pkg::DProdW'($signed(cfg_i.gain_d));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d_prod_q <= d_prod_d;
      err_q    <= err_i;
    end
  end

  assign p_prod_o = p_prod_q;
  assign i_prod_o = i_prod_q;
  assign d_prod_o = d_prod_q;
  assign err_o    = err_q;

endmodule

FILE: rtl/core/pdms_out.sv
// Output stage: sum of terms, Q8.8 truncation, saturation and minimum-speed rule.
// Depends on pdms_pkg.
module pdms_out (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic signed [pdms_pkg::PProdW-1:0] p_prod_i,
  input  logic signed [pdms_pkg::IProdW-1:0] i_prod_i,
  input  logic signed [pdms_pkg::DProdW-1:0] d_prod_i,
  input  logic signed [pdms_pkg::ErrW-1:0]   err_i,
  input  logic [pdms_pkg::MinW-1:0]          min_speed_i,
  output logic signed [pdms_pkg::DataW-1:0]  drive_o,
  output logic signed [pdms_pkg::ErrW-1:0]   error_out_o
);

  logic signed [pdms_pkg::SumW-1:0]  sum;
  logic signed [pdms_pkg::SumW-1:0]  sum_adj;
  logic signed [pdms_pkg::QuotW-1:0] quot;
  logic signed [pdms_pkg::DataW-1:0] sat;
  logic signed [pdms_pkg::DataW-1:0] ms_pos;
  logic signed [pdms_pkg::DataW-1:0] ms_neg;
  logic signed [pdms_pkg::DataW-1:0] drive_d, drive_q;
  logic signed [pdms_pkg::ErrW-1:0]  err_q;

  assign sum = pdms_pkg::SumW'(p_prod_i) + pdms_pkg::SumW'(i_prod_i) +
               pdms_pkg::SumW'(d_prod_i);

  // Adding 255 to a negative sum makes the arithmetic shift round toward zero.
  assign sum_adj = sum + (sum[pdms_pkg::SumW-1] ? pdms_pkg::SumW'(255) : '0);
  assign quot    = sum_adj[pdms_pkg::SumW-1:8];

  always_comb begin
    if (quot > pdms_pkg::QuotW'(32767)) begin
      sat = 16'sh7fff;
    end else if (quot < -pdms_pkg::QuotW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = quot[pdms_pkg::DataW-1:0];
    end
  end

  assign ms_pos = {1'b0, min_speed_i};
  assign ms_neg = -ms_pos;

  always_comb begin
    drive_d = sat;
    if ((err_i == '0) && (sat <= 0)) begin
      drive_d = sat;
    end else if ((sat >= 0) && (sat <= ms_pos)) begin
      drive_d = ms_pos;
    end else if ((sat < 0) && (sat >= ms_neg)) begin
      drive_d = ms_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drive_d;
      err_q   <= err_i;
    end
  end

  assign drive_o     = drive_q;
  assign error_out_o = err_q;

endmodule

FILE: rtl/core/pid_drive_with_min_speed.sv
// PID drive controller with integral window and minimum drive speed.
// Accepts one request per cycle while out_stall_i does not hold the pipeline; four
// pipeline registers (input, error and integral, products, result), each of which
// advances whenever its successor frees up.
// Reset clears all valid bits, the integral and previous error, and loads register
// defaults (gains and minimum speed zero, integral window 40).
module pid_drive_with_min_speed (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdms_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pdms_pkg::DataW-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pdms_pkg::DataW-1:0]    target_i,
  input  logic signed [pdms_pkg::DataW-1:0]    measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pdms_pkg::DataW-1:0]    drive_o,
  output logic signed [pdms_pkg::ErrW-1:0]     error_out_o
);

  pdms_pkg::cfg_t cfg_q;

  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;
  logic accept;

  logic signed [pdms_pkg::DataW-1:0]  target_q, measured_q;
  logic signed [pdms_pkg::ErrW-1:0]   s1_err;
  logic signed [pdms_pkg::IntegW-1:0] s1_integ;
  logic signed [pdms_pkg::DerivW-1:0] s1_deriv;
  logic signed [pdms_pkg::PProdW-1:0] s2_p;
  logic signed [pdms_pkg::IProdW-1:0] s2_i;
  logic signed [pdms_pkg::DProdW-1:0] s2_d;
  logic signed [pdms_pkg::ErrW-1:0]   s2_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.min_speed  <= '0;
      cfg_q.int_window <= pdms_pkg::WindowReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdms_pkg::REG_GAIN_P:     cfg_q.gain_p     <= cfg_wdata_i;
        pdms_pkg::REG_GAIN_I:     cfg_q.gain_i     <= cfg_wdata_i;
        pdms_pkg::REG_GAIN_D:     cfg_q.gain_d     <= cfg_wdata_i;
        pdms_pkg::REG_MIN_SPEED:  cfg_q.min_speed  <= cfg_wdata_i[pdms_pkg::MinW-1:0];
        pdms_pkg::REG_INT_WINDOW: cfg_q.int_window <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  assign en3    = !v3_q || !out_stall_i;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign en0    = !v0_q || en1;
  assign accept = in_valid_i && en0;

  assign in_stall_o  = !en0;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q   <= target_i;
      measured_q <= measured_i;
    end
  end

  pdms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (en1 && v0_q),
    .target_i   (target_q),
    .measured_i (measured_q),
    .window_i   (cfg_q.int_window),
    .err_o      (s1_err),
    .integ_o    (s1_integ),
    .deriv_o    (s1_deriv)
  );

  pdms_mult u_mult (
    .clk_i    (clk_i),
    .load_i   (en2 && v1_q),
    .err_i    (s1_err),
    .integ_i  (s1_integ),
    .deriv_i  (s1_deriv),
    .cfg_i    (cfg_q),
    .p_prod_o (s2_p),
    .i_prod_o (s2_i),
    .d_prod_o (s2_d),
    .err_o    (s2_err)
  );

  pdms_out u_out (
    .clk_i       (clk_i),
    .load_i      (en3 && v2_q),
    .p_prod_i    (s2_p),
    .i_prod_i    (s2_i),
    .d_prod_i    (s2_d),
    .err_i       (s2_err),
    .min_speed_i (cfg_q.min_speed),
    .drive_o     (drive_o),
    .error_out_o (error_out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although the output side is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !v2_q |=> v2_q)
    else $error("request lost between integral and multiply stages");

endmodule
